// File: rtl/sstk_pkg.sv
package sstk_pkg;

  // Fixed field widths
  localparam int FUNC_W = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FIND = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL  = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } ctrl_state_t;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_TOP,
    RD_FIRST,
    RD_NEXT
  } rd_sel_t;

  // Result value source
  typedef enum logic [1:0] {
    RV_ZERO,
    RV_OPERAND,
    RV_RDATA
  } res_val_t;

  typedef struct packed {
    logic              latch_val;
    logic              mem_wr;
    logic              wr_shift;
    logic              rd_en;
    rd_sel_t           rd_sel;
    logic              ptr_first;
    logic              ptr_inc;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              res_ld;
    logic [STAT_W-1:0] res_status;
    res_val_t          res_val;
    logic              res_idx;
    logic              out_ld;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic at_end;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/sstk_ctrl.sv
module sstk_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [sstk_pkg::FUNC_W-1:0]  in_func,
  output logic                         in_ready,
  input  sstk_pkg::stat_t              stat,
  output sstk_pkg::cmd_t               cmd
);

  sstk_pkg::ctrl_state_t state_r, state_nxt;
  logic                  del_r, del_nxt;
  logic                  accept;

  assign in_ready = (state_r == sstk_pkg::S_IDLE);
  assign accept   = in_ready & in_valid;

  // Remember whether the walk is a delete
  assign del_nxt = accept ? (in_func == sstk_pkg::FN_DEL) : del_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sstk_pkg::S_IDLE;
      del_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      del_r   <= del_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sstk_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_func) inside
            sstk_pkg::FN_POP, sstk_pkg::FN_PEEK:
              state_nxt = stat.empty ? sstk_pkg::S_RESP : sstk_pkg::S_RDWAIT;
            sstk_pkg::FN_FIND, sstk_pkg::FN_DEL:
              state_nxt = stat.empty ? sstk_pkg::S_RESP : sstk_pkg::S_SCAN;
            default:
              state_nxt = sstk_pkg::S_RESP;
          endcase
        end
      end
      sstk_pkg::S_RDWAIT: state_nxt = sstk_pkg::S_RESP;
      sstk_pkg::S_SCAN: begin
        if (stat.match) begin
          state_nxt = (del_r && !stat.at_end) ? sstk_pkg::S_SHIFT : sstk_pkg::S_RESP;
        end else if (stat.at_end) begin
          state_nxt = sstk_pkg::S_RESP;
        end
      end
      sstk_pkg::S_SHIFT: begin
        if (stat.at_end) state_nxt = sstk_pkg::S_RESP;
      end
      sstk_pkg::S_RESP: begin
        if (stat.out_free) state_nxt = sstk_pkg::S_IDLE;
      end
      default: state_nxt = sstk_pkg::S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      sstk_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.latch_val = 1'b1;
          unique case (in_func) inside
            sstk_pkg::FN_PUSH: begin
              cmd.res_ld = 1'b1;
              if (stat.full) begin
                cmd.res_status = sstk_pkg::ST_FULL;
              end else begin
                cmd.mem_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.res_val = sstk_pkg::RV_OPERAND;
              end
            end
            sstk_pkg::FN_POP, sstk_pkg::FN_PEEK: begin
              if (stat.empty) begin
                cmd.res_ld     = 1'b1;
                cmd.res_status = sstk_pkg::ST_EMPTY;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = sstk_pkg::RD_TOP;
                cmd.cnt_dec = (in_func == sstk_pkg::FN_POP);
              end
            end
            sstk_pkg::FN_FIND, sstk_pkg::FN_DEL: begin
              if (stat.empty) begin
                cmd.res_ld     = 1'b1;
                cmd.res_status = sstk_pkg::ST_EMPTY;
              end else begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = sstk_pkg::RD_FIRST;
                cmd.ptr_first = 1'b1;
              end
            end
            default: begin
              // unused codes: empty ok result
              cmd.res_ld = 1'b1;
            end
          endcase
        end
      end
      sstk_pkg::S_RDWAIT: begin
        cmd.res_ld  = 1'b1;
        cmd.res_val = sstk_pkg::RV_RDATA;
      end
      sstk_pkg::S_SCAN: begin
        if (stat.match) begin
          cmd.res_ld  = 1'b1;
          cmd.res_val = sstk_pkg::RV_RDATA;
          cmd.res_idx = 1'b1;
          if (del_r) begin
            if (stat.at_end) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = sstk_pkg::RD_NEXT;
              cmd.ptr_inc = 1'b1;
            end
          end
        end else if (stat.at_end) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = sstk_pkg::ST_MISSING;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = sstk_pkg::RD_NEXT;
          cmd.ptr_inc = 1'b1;
        end
      end
      sstk_pkg::S_SHIFT: begin
        // move the word just read down one place
        cmd.mem_wr   = 1'b1;
        cmd.wr_shift = 1'b1;
        if (stat.at_end) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = sstk_pkg::RD_NEXT;
          cmd.ptr_inc = 1'b1;
        end
      end
      sstk_pkg::S_RESP: cmd.out_ld = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/sstk_dpath.sv
module sstk_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [sstk_pkg::DATA_W-1:0] in_operand_value,
  input  sstk_pkg::cmd_t                     cmd,
  output sstk_pkg::stat_t                    stat,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [sstk_pkg::STAT_W-1:0]        out_status,
  output logic signed [sstk_pkg::DATA_W-1:0] out_result_value,
  output logic [sstk_pkg::IDX_W-1:0]         out_match_index,
  output logic [sstk_pkg::CNT_W-1:0]         out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [sstk_pkg::DATA_W-1:0] mem [DEPTH];
  logic [sstk_pkg::DATA_W-1:0] rdata_r;
  logic [sstk_pkg::DATA_W-1:0] val_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               ptr_r, ptr_nxt;
  logic [CW-1:0]               top_m1, ptr_m1, ptr_m2;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [sstk_pkg::DATA_W-1:0] wr_data;

  logic [sstk_pkg::STAT_W-1:0] res_status_r;
  logic [sstk_pkg::DATA_W-1:0] res_value_r;
  logic [AW-1:0]               res_index_r;

  logic                        out_valid_r;
  logic [sstk_pkg::STAT_W-1:0] out_status_r;
  logic [sstk_pkg::DATA_W-1:0] out_value_r;
  logic [sstk_pkg::IDX_W-1:0]  out_index_r;
  logic [sstk_pkg::CNT_W-1:0]  out_count_r;
  logic [31:0]                 idx_ext, cnt_ext;

  assign top_m1 = count_r - CW'(1);
  assign ptr_m1 = ptr_r - CW'(1);
  assign ptr_m2 = ptr_r - CW'(2);

  // Status back to the controller
  assign stat.full     = (count_r == CW'(DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.match    = (rdata_r == val_r);
  assign stat.at_end   = (ptr_r == count_r);
  assign stat.out_free = !out_valid_r || out_ready;

  // Memory addressing
  always_comb begin
    case (cmd.rd_sel)
      sstk_pkg::RD_TOP:   rd_addr = top_m1[AW-1:0];
      sstk_pkg::RD_FIRST: rd_addr = '0;
      default:            rd_addr = ptr_r[AW-1:0];
    endcase
  end

  assign wr_addr = cmd.wr_shift ? ptr_m2[AW-1:0] : count_r[AW-1:0];
  assign wr_data = cmd.wr_shift ? rdata_r : in_operand_value;

  // Stack storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[wr_addr] <= wr_data;
    if (cmd.rd_en)  rdata_r <= mem[rd_addr];
  end

  // Fill count and walk pointer
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc)      count_nxt = count_r + CW'(1);
    else if (cmd.cnt_dec) count_nxt = count_r - CW'(1);
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_first)    ptr_nxt = CW'(1);
    else if (cmd.ptr_inc) ptr_nxt = ptr_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.latch_val) val_r <= in_operand_value;
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_status_r <= cmd.res_status;
      res_index_r  <= cmd.res_idx ? ptr_m1[AW-1:0] : '0;
      case (cmd.res_val)
        sstk_pkg::RV_OPERAND: res_value_r <= in_operand_value;
        sstk_pkg::RV_RDATA:   res_value_r <= rdata_r;
        default:              res_value_r <= '0;
      endcase
    end
  end

  // Output register
  assign idx_ext = 32'(res_index_r);
  assign cnt_ext = 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_index_r  <= idx_ext[sstk_pkg::IDX_W-1:0];
      out_count_r  <= cnt_ext[sstk_pkg::CNT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_match_index  = out_index_r;
  assign out_entry_count  = out_count_r;

endmodule

// File: rtl/searchable_stack_unit.sv
// Stack of signed words with push, pop, peek, find-first and delete-first-match.
// One item at a time; find/delete walk the memory one entry a cycle.
// Synchronous active-low reset empties the stack; stored words are not cleared.
module searchable_stack_unit #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sstk_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [sstk_pkg::DATA_W-1:0] in_operand_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sstk_pkg::STAT_W-1:0]        out_status,
  output logic signed [sstk_pkg::DATA_W-1:0] out_result_value,
  output logic [sstk_pkg::IDX_W-1:0]         out_match_index,
  output logic [sstk_pkg::CNT_W-1:0]         out_entry_count
);

  sstk_pkg::cmd_t  cmd;
  sstk_pkg::stat_t stat;

  sstk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sstk_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operand_value (in_operand_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_match_index  (out_match_index),
    .out_entry_count  (out_entry_count)
  );

endmodule
